// ===== rtl/core/a2i_pkg.sv =====
// Shared types and constants for the ASCII to integer parser.
// Payload structs for both channels and the character codes the parser tests.
// No dependencies.
package a2i_pkg;

	// Widths of the fields and of the position counters
	localparam int unsigned CH_W    = 8;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned RADIX_W = 5;

	// Position and end index saturate at this length
	localparam logic [POS_W-1:0] MAX_LEN = 8'd255;

	// Base used after a reset, the value that selects automatic mode and the bases picked in it
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_AUTO  = 5'd0;
	localparam logic [RADIX_W-1:0] BASE_OCT    = 5'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC    = 5'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX    = 5'd16;

	// Character codes
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_UA    = 8'h41;
	localparam logic [CH_W-1:0] CH_UF    = 8'h46;
	localparam logic [CH_W-1:0] CH_UX    = 8'h58;
	localparam logic [CH_W-1:0] CH_LA    = 8'h61;
	localparam logic [CH_W-1:0] CH_LF    = 8'h66;
	localparam logic [CH_W-1:0] CH_LX    = 8'h78;

	// One character of the string
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} req_t;

	// One parse result
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        end_pos;
	} rsp_t;

endpackage

// ===== rtl/core/ascii_to_integer_parser.sv =====
// strtol style parser: one character per item, one result per string.
// A last item is held in the input register and then loads the result register, which drives rsp;
// a held result in the result register can keep it waiting in the input register.
// Throughput: one item per cycle; the input register and the result register
// decouple the two channels, so only a held result plus a held last item stalls.
// Reset (arst_n low, asynchronous) empties both registers, clears the parse
// state and sets radix to 10.
module ascii_to_integer_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  a2i_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output a2i_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [a2i_pkg::RADIX_W-1:0]   cfg_wdata
);

	logic [a2i_pkg::RADIX_W-1:0] radix_q;
	logic                        valid_s1;
	a2i_pkg::req_t               item_s1;
	logic                        rsp_valid_q;
	a2i_pkg::rsp_t               rsp_q;
	a2i_pkg::rsp_t               result;
	logic                        out_free;
	logic                        go_s1;

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= a2i_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Stage 1 item moves on unless it closes a string and the result slot is held
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign go_s1     = valid_s1 && (!item_s1.last || out_free);
	assign req_ready = !valid_s1 || go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	a2i_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.radix  (radix_q),
		.fire   (go_s1),
		.item   (item_s1),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= go_s1 && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && item_s1.last) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A new result only ever comes from a last item leaving stage 1
	a_rsp_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(go_s1 && item_s1.last))
		else $error("result appeared without a last item");

	// A stalled stage 1 item is kept, not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled item lost from stage 1");

	// Input stalls only behind a held result and a waiting last item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && item_s1.last && rsp_valid_q && !rsp_ready))
		else $error("input stalled without cause");

	// A held result is not overwritten
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("held result changed");

endmodule

// ===== rtl/core/a2i_core.sv =====
// Parse state machine of the ASCII to integer parser: holds the running state
// and works out the next state and the result for one character.
// Depends on a2i_pkg.
module a2i_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [a2i_pkg::RADIX_W-1:0]    radix,
	input  logic                           fire,
	input  a2i_pkg::req_t                  item,
	output a2i_pkg::rsp_t                  result
);

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t                          ph_q, ph_d;
	logic [a2i_pkg::VAL_W-1:0]       acc_q, acc_d;
	logic                            neg_q, neg_d;
	logic [a2i_pkg::RADIX_W-1:0]     base_q, base_d;
	logic [a2i_pkg::POS_W-1:0]       pos_q, stop_q, stop_d;

	logic [a2i_pkg::POS_W-1:0]       pos_inc;
	logic [a2i_pkg::CH_W-1:0]        c;
	logic                            is_space;
	logic                            dig_ok;
	logic [a2i_pkg::RADIX_W-1:0]     dig_val;
	logic [a2i_pkg::RADIX_W-1:0]     base_sel;
	logic [a2i_pkg::RADIX_W-1:0]     base_use;
	logic [a2i_pkg::VAL_W+a2i_pkg::RADIX_W-1:0] prod;
	logic [a2i_pkg::VAL_W-1:0]       mac;
	logic                            take_ok;

	assign c = item.ch;

	// Saturating index of the next character
	assign pos_inc = (pos_q == a2i_pkg::MAX_LEN) ? a2i_pkg::MAX_LEN : pos_q + 1'b1;

	assign is_space = (c == a2i_pkg::CH_SPACE) ||
		((c >= a2i_pkg::CH_TAB) && (c <= a2i_pkg::CH_CR));

	// Digit decode, upper and lower case hex letters
	always_comb begin
		dig_ok  = 1'b1;
		dig_val = '0;
		if ((c >= a2i_pkg::CH_0) && (c <= a2i_pkg::CH_9)) begin
			dig_val = a2i_pkg::RADIX_W'(c - a2i_pkg::CH_0);
		end else if ((c >= a2i_pkg::CH_LA) && (c <= a2i_pkg::CH_LF)) begin
			dig_val = a2i_pkg::RADIX_W'(c - a2i_pkg::CH_LA) + a2i_pkg::BASE_DEC;
		end else if ((c >= a2i_pkg::CH_UA) && (c <= a2i_pkg::CH_UF)) begin
			dig_val = a2i_pkg::RADIX_W'(c - a2i_pkg::CH_UA) + a2i_pkg::BASE_DEC;
		end else begin
			dig_ok = 1'b0;
		end
	end

	// Base picked on the first non-space character, otherwise the held base
	assign base_sel = (radix == a2i_pkg::RADIX_AUTO) ? a2i_pkg::BASE_DEC : radix;
	assign base_use = (ph_q == PH_SPACE) ? base_sel : base_q;

	// One multiply-add per character, wrapping at 32 bits
	assign prod    = acc_q * base_use;
	assign mac     = prod[a2i_pkg::VAL_W-1:0] + {{(a2i_pkg::VAL_W-a2i_pkg::RADIX_W){1'b0}}, dig_val};
	assign take_ok = dig_ok && (dig_val < base_use);

	// Next parse state for this character
	always_comb begin
		ph_d   = ph_q;
		acc_d  = acc_q;
		neg_d  = neg_q;
		base_d = base_q;
		stop_d = stop_q;
		unique case (ph_q)
			PH_SPACE: begin
				if (c == a2i_pkg::CH_NUL) begin
					ph_d = PH_DONE;
				end else if (!is_space) begin
					if ((radix == a2i_pkg::RADIX_AUTO) && (c == a2i_pkg::CH_0)) begin
						base_d = a2i_pkg::BASE_OCT;
						acc_d  = '0;
						stop_d = pos_inc;
						ph_d   = PH_ZERO;
					end else begin
						base_d = base_sel;
						if (c == a2i_pkg::CH_PLUS) begin
							ph_d = PH_DIGITS;
						end else if (c == a2i_pkg::CH_MINUS) begin
							neg_d = 1'b1;
							ph_d  = PH_DIGITS;
						end else if (take_ok) begin
							acc_d  = mac;
							stop_d = pos_inc;
							ph_d   = PH_DIGITS;
						end else begin
							ph_d = PH_DONE;
						end
					end
				end
			end
			PH_ZERO: begin
				if ((c == a2i_pkg::CH_LX) || (c == a2i_pkg::CH_UX)) begin
					base_d = a2i_pkg::BASE_HEX;
					ph_d   = PH_DIGITS;
				end else if (take_ok) begin
					acc_d  = mac;
					stop_d = pos_inc;
					ph_d   = PH_DIGITS;
				end else begin
					ph_d = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (take_ok) begin
					acc_d  = mac;
					stop_d = pos_inc;
				end else begin
					ph_d = PH_DONE;
				end
			end
			PH_DONE: begin
				ph_d = PH_DONE;
			end
			default: begin
				ph_d = PH_DONE;
			end
		endcase
	end

	// Result seen after this character
	assign result.value   = neg_d ? -acc_d : acc_d;
	assign result.end_pos = stop_d;

	// State registers; a last item puts the parse back to its start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SPACE;
			acc_q  <= '0;
			neg_q  <= 1'b0;
			base_q <= '0;
			pos_q  <= '0;
			stop_q <= '0;
		end else if (fire) begin
			if (item.last) begin
				ph_q   <= PH_SPACE;
				acc_q  <= '0;
				neg_q  <= 1'b0;
				base_q <= '0;
				pos_q  <= '0;
				stop_q <= '0;
			end else begin
				ph_q   <= ph_d;
				acc_q  <= acc_d;
				neg_q  <= neg_d;
				base_q <= base_d;
				pos_q  <= pos_inc;
				stop_q <= stop_d;
			end
		end
	end

endmodule
